// ===== src/splim_pkg.sv =====
// shared types, widths and codes for the stepper positioner
// no dependencies

package splim_pkg;

    localparam int DEPTH_W   = 8;
    localparam int DESIRED_W = 10;
    localparam int STEPS_W   = 16;
    localparam int COIL_W    = 4;
    localparam int STOP_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int DIFF_W    = DESIRED_W + 1;
    localparam int PROD_W    = DIFF_W + CFG_DAT_W + 1;

    localparam logic [CFG_DAT_W-1:0] MAX_DEPTH_RST    = 8'd100;
    localparam logic [CFG_DAT_W-1:0] STEPS_PER_MM_RST = 8'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 1'd1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    localparam logic [STOP_W-1:0] STOP_NONE = 2'd0;
    localparam logic [STOP_W-1:0] STOP_HOME = 2'd1;
    localparam logic [STOP_W-1:0] STOP_FAR  = 2'd2;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'h0;

    typedef struct packed {
        logic [DEPTH_W-1:0]        current;
        logic [DEPTH_W-1:0]        target;
        logic signed [STEPS_W-1:0] steps;
        logic [COIL_W-1:0]         coil;
    } t_state;

    typedef struct packed {
        logic [COIL_W-1:0]  coils;
        logic               busy;
        logic [DEPTH_W-1:0] depth;
        logic [STOP_W-1:0]  stop;
    } t_result;

    function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        unique case (phase)
            2'd0:    pat = 4'h5;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hA;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/splim_ifs.sv =====
// valid/ready channel interfaces for the stepper positioner
// depends on splim_pkg for field widths

interface splim_in_if import splim_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic signed [DESIRED_W-1:0] req_depth;
    logic                        home_pressed;
    logic                        far_pressed;

    modport source (output valid, kind, req_depth, home_pressed, far_pressed,
                    input ready);
    modport sink   (input valid, kind, req_depth, home_pressed, far_pressed,
                    output ready);
endinterface

interface splim_out_if import splim_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COIL_W-1:0]  coils;
    logic               busy_res;
    logic [DEPTH_W-1:0] depth_now;
    logic [STOP_W-1:0]  limit_stop;

    modport source (output valid, coils, busy_res, depth_now, limit_stop, input ready);
    modport sink   (input valid, coils, busy_res, depth_now, limit_stop, output ready);
endinterface

interface splim_cfg_if import splim_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/splim_step.sv =====
// next-state and result logic for one item of the stepper positioner
// depends on splim_pkg

module splim_step import splim_pkg::*; (
    input  logic                        i_kind,
    input  logic signed [DESIRED_W-1:0] i_desired,
    input  logic                        i_home,
    input  logic                        i_far,
    input  logic [CFG_DAT_W-1:0]        i_max_depth,
    input  logic [CFG_DAT_W-1:0]        i_steps_per_mm,
    input  t_state                      i_state,
    output t_state                      o_state,
    output t_result                     o_result
);

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [STEPS_W-1:0] sat;
    logic                      cmd_ok;
    logic [DEPTH_W-1:0]        new_target;
    logic                      pos;
    logic [1:0]                phase;
    logic [COIL_W-1:0]         pat;

    always_comb begin
        diff = DIFF_W'(i_desired) - $signed({3'b000, i_state.current});
        prod = diff * $signed({1'b0, i_steps_per_mm});
        if (prod > PROD_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (prod < -PROD_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = prod[STEPS_W-1:0];
        end
        cmd_ok = (i_state.steps == '0)
              && (DIFF_W'(i_desired) <= $signed({3'b000, i_max_depth}))
              && (i_desired != $signed({2'b00, i_state.current}));
        new_target = i_desired[DESIRED_W-1] ? '0 : i_desired[DEPTH_W-1:0];
    end

    always_comb begin
        pos = !i_state.steps[STEPS_W-1];
        if (pos) begin
            phase = i_state.steps[1:0];
        end else begin
            phase = ~(2'd0 - i_state.steps[1:0]);
        end
        pat = coil_of(phase);
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.coils = COILS_OFF;
        o_result.stop  = STOP_NONE;
        if (i_kind == KIND_MOVE) begin
            if (cmd_ok) begin
                o_state.target = new_target;
                o_state.steps  = sat;
                if (sat == '0) begin
                    o_state.current = new_target;
                    o_state.coil    = COILS_OFF;
                end
            end
            o_result.coils = o_state.coil;
        end else if (i_state.steps != '0) begin
            if (i_home && !pos) begin
                o_state.steps   = '0;
                o_state.current = '0;
                o_state.coil    = COILS_OFF;
                o_result.stop   = STOP_HOME;
            end else if (i_far && !i_home && pos) begin
                o_state.steps   = '0;
                o_state.current = i_state.target;
                o_state.coil    = COILS_OFF;
                o_result.stop   = STOP_FAR;
            end else begin
                o_state.steps  = pos ? i_state.steps - 16'sd1 : i_state.steps + 16'sd1;
                o_state.coil   = pat;
                o_result.coils = pat;
                if (o_state.steps == '0) begin
                    o_state.current = i_state.target;
                    o_state.coil    = COILS_OFF;
                end
            end
        end
        o_result.busy  = (o_state.steps != '0);
        o_result.depth = o_state.current;
    end

endmodule

// ===== src/stepper_position_with_limit_switches.sv =====
// top level of the stepper positioner: input register, step logic, result register
// depends on splim_pkg, splim_ifs and splim_step
//
// usage
//   i_in carries one item per transfer: a tick (one motor period, with the limit
//   switch levels) or a move command with a desired depth in millimetres
//   o_out returns exactly one result per item: coil bits, busy flag, recorded
//   depth and the limit stop code, in item order
//   i_cfg writes max_depth (index 0) or steps_per_mm (index 1); always ready,
//   write only while no item is in flight
// timing
//   an item is held in the input register, and its result is registered in the result
//   register once that register is empty or being taken; o_out.valid comes from the
//   result register
//   one item per cycle sustained while o_out takes results; the single step-logic pass sets that figure
// reset
//   depth, target, step count and coils clear; max_depth 100, steps_per_mm 20
// stall
//   when o_out is held off the result register holds, the input register still
//   takes one item, then i_in.ready drops until the result is taken

module stepper_position_with_limit_switches import splim_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    splim_in_if.sink      i_in,
    splim_out_if.source   o_out,
    splim_cfg_if.sink     i_cfg
);

    logic                        r_in_vld;
    logic                        r_kind;
    logic signed [DESIRED_W-1:0] r_desired;
    logic                        r_home;
    logic                        r_far;
    logic                        r_out_vld;
    t_result                     r_out;
    t_state                      r_state;
    logic [CFG_DAT_W-1:0]        r_max_depth;
    logic [CFG_DAT_W-1:0]        r_steps_per_mm;

    t_state  n_state;
    t_result n_out;
    logic    fire;
    logic    in_xfer;

    assign fire    = r_in_vld && (!r_out_vld || o_out.ready);
    assign in_xfer = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_vld || fire;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_vld;
    assign o_out.coils      = r_out.coils;
    assign o_out.busy_res   = r_out.busy;
    assign o_out.depth_now  = r_out.depth;
    assign o_out.limit_stop = r_out.stop;

    splim_step u_step (
        .i_kind         (r_kind),
        .i_desired      (r_desired),
        .i_home         (r_home),
        .i_far          (r_far),
        .i_max_depth    (r_max_depth),
        .i_steps_per_mm (r_steps_per_mm),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_state        <= '0;
            r_max_depth    <= MAX_DEPTH_RST;
            r_steps_per_mm <= STEPS_PER_MM_RST;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_MAX_DEPTH:    r_max_depth    <= i_cfg.data;
                    CFG_STEPS_PER_MM: r_steps_per_mm <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind    <= i_in.kind;
            r_desired <= i_in.req_depth;
            r_home    <= i_in.home_pressed;
            r_far     <= i_in.far_pressed;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule
